[rtl/afb_pkg.sv]
// Package of the activation forward/backward unit: default sizes, the
// activation code, the pipeline control struct and the functions that build
// the sigmoid and tanh interpolation tables at elaboration.
package afb_pkg;

   localparam int AFB_DATA_WIDTH    = 16;
   localparam int AFB_FRAC_BITS     = 11;
   localparam int AFB_TABLE_ENTRIES = 256;

   // Register index of the activation kind register (byte address 0).
   localparam logic CSR_IDX_KIND = 1'b0;

   typedef enum logic [1:0] {
      KIND_SIGMOID = 2'd0,
      KIND_RELU    = 2'd1,
      KIND_TANH    = 2'd2,
      KIND_NONE    = 2'd3
   } kind_type;

   typedef struct packed {
      logic     valid;
      logic     backward;
      kind_type kind;
   } ctl_type;

   localparam longint Q31_ONE  = longint'(1) << 31;
   localparam longint Q31_HALF = longint'(1) << 30;

   // Restoring long division, evaluated only while the tables are built.
   function automatic longint unsigned long_div(input longint unsigned num,
                                                input longint unsigned den);
      longint unsigned rem;
      longint unsigned quo;
      rem = '0;
      quo = '0;
      for (int i = 63; i >= 0; i--) begin
         rem = {rem[62:0], num[i]};
         if (rem >= den) begin
            rem    = rem - den;
            quo[i] = 1'b1;
         end
      end
      return quo;
   endfunction

   function automatic longint q31_mul(input longint a, input longint b);
      return (a * b + Q31_HALF) >>> 31;
   endfunction

   // exp(-|x_k|) in Q31: a fifth-order series on |x_k|/256, squared 8 times.
   function automatic longint exp_neg_q31(input longint k, input longint entries);
      longint dk;
      longint ad;
      longint r;
      longint term;
      longint e;
      dk = 2 * k - entries;
      ad = (dk < 0) ? -dk : dk;
      r  = longint'(long_div(longint'(unsigned'((ad << 26) + (entries >>> 1))),
                             longint'(unsigned'(entries))));
      term = Q31_ONE;
      e    = Q31_ONE;
      term = q31_mul(term, r);
      e    = e - term;
      term = q31_mul(term, r) / 2;
      e    = e + term;
      term = q31_mul(term, r) / 3;
      e    = e - term;
      term = q31_mul(term, r) / 4;
      e    = e + term;
      term = q31_mul(term, r) / 5;
      e    = e - term;
      for (int n = 0; n < 8; n++) begin
         e = q31_mul(e, e);
      end
      return e;
   endfunction

   function automatic longint sigmoid_point(input longint k, input longint entries,
                                            input longint frac_bits);
      longint e;
      longint den;
      longint num;
      e   = exp_neg_q31(k, entries);
      den = Q31_ONE + e;
      if (2 * k - entries < 0) begin
         num = (e << frac_bits) + (den >>> 1);
      end else begin
         num = (Q31_ONE << frac_bits) + (den >>> 1);
      end
      return longint'(long_div(num, den));
   endfunction

   function automatic longint tanh_point(input longint k, input longint entries,
                                         input longint frac_bits);
      longint e;
      longint e2;
      longint den;
      longint mag;
      e   = exp_neg_q31(k, entries);
      e2  = q31_mul(e, e);
      den = Q31_ONE + e2;
      mag = longint'(long_div(((Q31_ONE - e2) << frac_bits) + (den >>> 1), den));
      return (2 * k - entries < 0) ? -mag : mag;
   endfunction

endpackage

[rtl/afb_csr.sv]
// Configuration register file of the activation unit: APB-style write and
// read of the activation kind register. Depends on afb_pkg.
module afb_csr (
   input  logic              clock,
   input  logic              reset,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [2:0]        paddr,
   input  logic [31:0]       pwdata,
   output logic [31:0]       prdata,
   output logic              pready,
   output afb_pkg::kind_type kind
);
   import afb_pkg::*;

   kind_type kind_ff;
   kind_type kind_in;
   logic     write_kind;

   assign pready     = 1'b1;
   assign write_kind = psel && penable && pwrite && (paddr[2] == CSR_IDX_KIND);

   always_comb begin
      kind_in = kind_ff;
      if (write_kind) begin
         kind_in = kind_type'(pwdata[1:0]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         kind_ff <= KIND_SIGMOID;
      end else begin
         kind_ff <= kind_in;
      end
   end

   assign kind   = kind_ff;
   assign prdata = (paddr[2] == CSR_IDX_KIND) ? {30'd0, kind_ff} : 32'd0;

   a_kind_written: assert property (@(posedge clock) disable iff (reset)
      (psel && penable && pwrite && (paddr[2] == CSR_IDX_KIND))
      |=> (kind_ff == $past(pwdata[1:0])))
      else $error("activation kind register did not take the written value");

endmodule

[rtl/afb_interp.sv]
// Table stages of the activation unit: index and fraction, table read,
// slope product and interpolated sigmoid or tanh value (four stages).
// Depends on afb_pkg for the control struct and the table functions.
module afb_interp #(
   parameter int DATA_WIDTH    = afb_pkg::AFB_DATA_WIDTH,
   parameter int FRAC_BITS     = afb_pkg::AFB_FRAC_BITS,
   parameter int TABLE_ENTRIES = afb_pkg::AFB_TABLE_ENTRIES
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         advance,
   input  afb_pkg::ctl_type             up_ctl,
   input  logic signed [DATA_WIDTH-1:0] up_x,
   input  logic signed [DATA_WIDTH-1:0] up_g,
   output afb_pkg::ctl_type             dn_ctl,
   output logic signed [FRAC_BITS+1:0]  dn_f,
   output logic signed [DATA_WIDTH-1:0] dn_x,
   output logic signed [DATA_WIDTH-1:0] dn_g
);
   import afb_pkg::*;

   localparam int TW     = FRAC_BITS + 2;
   localparam int FW     = FRAC_BITS + 4;
   localparam int UW     = DATA_WIDTH + 6;
   localparam int IW     = $clog2(TABLE_ENTRIES + 1);
   localparam int PW     = UW + IW;
   localparam int PDW    = TW + FW + 2;
   localparam int TabLen = TABLE_ENTRIES + 1;

   localparam logic [UW-1:0] Offset = UW'(longint'(8) << FRAC_BITS);
   localparam logic [UW-1:0] Span   = UW'(longint'(16) << FRAC_BITS);
   localparam logic signed [PDW-1:0] HalfFw = PDW'(longint'(1) << (FW - 1));
   localparam logic signed [TW-1:0]  One    = TW'(longint'(1) << FRAC_BITS);

   logic signed [TW-1:0] sig_tab  [TabLen];
   logic signed [TW-1:0] tanh_tab [TabLen];

   for (genvar k = 0; k < TabLen; k++) begin : g_tab
      localparam logic signed [TW-1:0] SigPoint =
         TW'(sigmoid_point(longint'(k), longint'(TABLE_ENTRIES), longint'(FRAC_BITS)));
      localparam logic signed [TW-1:0] TanhPoint =
         TW'(tanh_point(longint'(k), longint'(TABLE_ENTRIES), longint'(FRAC_BITS)));
      assign sig_tab[k]  = SigPoint;
      assign tanh_tab[k] = TanhPoint;
   end

   ctl_type ctl1_ff, ctl2_ff, ctl3_ff, ctl4_ff;
   logic signed [DATA_WIDTH-1:0] x1_ff, x2_ff, x3_ff, x4_ff;
   logic signed [DATA_WIDTH-1:0] g1_ff, g2_ff, g3_ff, g4_ff;

   logic [UW-1:0]  u;
   logic [PW-1:0]  p;
   logic [IW-1:0]  idx1_in, idx1_ff, idxh1_in, idxh1_ff;
   logic [FW-1:0]  frac1_in, frac1_ff, frac2_ff;
   logic signed [TW-1:0]  lo2_in, lo2_ff, hi2_in, hi2_ff, lo3_ff;
   logic signed [TW:0]    diff;
   logic signed [PDW-1:0] prod3_in, prod3_ff;
   logic signed [PDW-1:0] step;
   logic signed [TW-1:0]  f4_in, f4_ff;

   // Stage 1: offset x into [0, 16) and split it into index and fraction.
   always_comb begin
      u        = UW'(up_x) + Offset;
      p        = '0;
      idx1_in  = '0;
      frac1_in = '0;
      if (u[UW-1]) begin
         idx1_in = '0;
      end else if (u >= Span) begin
         idx1_in = IW'(TABLE_ENTRIES);
      end else begin
         p        = PW'(u) * PW'(TABLE_ENTRIES);
         idx1_in  = p[FW +: IW];
         frac1_in = p[FW-1:0];
      end
      idxh1_in = (idx1_in == IW'(TABLE_ENTRIES)) ? idx1_in : idx1_in + 1'b1;
   end

   // Stage 2: read the two neighboring points of the selected table.
   always_comb begin
      if (ctl1_ff.kind == KIND_TANH) begin
         lo2_in = tanh_tab[idx1_ff];
         hi2_in = tanh_tab[idxh1_ff];
      end else begin
         lo2_in = sig_tab[idx1_ff];
         hi2_in = sig_tab[idxh1_ff];
      end
   end

   // Stage 3: slope times fraction.
   always_comb begin
      diff     = (TW+1)'(hi2_ff) - (TW+1)'(lo2_ff);
      prod3_in = PDW'(diff) * PDW'(signed'({1'b0, frac2_ff}));
   end

   // Stage 4: rounded step added to the lower point.
   always_comb begin
      step  = (prod3_ff + HalfFw) >>> FW;
      f4_in = TW'(PDW'(lo3_ff) + step);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl1_ff <= '0;
         ctl2_ff <= '0;
         ctl3_ff <= '0;
         ctl4_ff <= '0;
      end else if (advance) begin
         ctl1_ff <= up_ctl;
         ctl2_ff <= ctl1_ff;
         ctl3_ff <= ctl2_ff;
         ctl4_ff <= ctl3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         x1_ff    <= up_x;
         g1_ff    <= up_g;
         idx1_ff  <= idx1_in;
         idxh1_ff <= idxh1_in;
         frac1_ff <= frac1_in;
         x2_ff    <= x1_ff;
         g2_ff    <= g1_ff;
         lo2_ff   <= lo2_in;
         hi2_ff   <= hi2_in;
         frac2_ff <= frac1_ff;
         x3_ff    <= x2_ff;
         g3_ff    <= g2_ff;
         lo3_ff   <= lo2_ff;
         prod3_ff <= prod3_in;
         x4_ff    <= x3_ff;
         g4_ff    <= g3_ff;
         f4_ff    <= f4_in;
      end
   end

   assign dn_ctl = ctl4_ff;
   assign dn_f   = f4_ff;
   assign dn_x   = x4_ff;
   assign dn_g   = g4_ff;

   a_sigmoid_range: assert property (@(posedge clock) disable iff (reset)
      (ctl4_ff.valid && ctl4_ff.kind == KIND_SIGMOID) |-> (f4_ff >= 0 && f4_ff <= One))
      else $error("interpolated sigmoid left the range zero to one");

   a_tanh_range: assert property (@(posedge clock) disable iff (reset)
      (ctl4_ff.valid && ctl4_ff.kind == KIND_TANH) |-> (f4_ff >= -One && f4_ff <= One))
      else $error("interpolated tanh left the range minus one to one");

endmodule

[rtl/afb_grad.sv]
// Derivative and output stages of the activation unit: derivative product,
// derivative, gradient product, then rounding, mode select and saturation.
// Depends on afb_pkg for the control struct and the activation codes.
module afb_grad #(
   parameter int DATA_WIDTH = afb_pkg::AFB_DATA_WIDTH,
   parameter int FRAC_BITS  = afb_pkg::AFB_FRAC_BITS
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         advance,
   input  afb_pkg::ctl_type             up_ctl,
   input  logic signed [FRAC_BITS+1:0]  up_f,
   input  logic signed [DATA_WIDTH-1:0] up_x,
   input  logic signed [DATA_WIDTH-1:0] up_g,
   output logic                         dn_valid,
   output logic signed [DATA_WIDTH-1:0] dn_value
);
   import afb_pkg::*;

   localparam int TW = FRAC_BITS + 2;
   localparam int MW = 2 * TW;
   localparam int GW = DATA_WIDTH + TW;

   localparam logic signed [TW-1:0] One     = TW'(longint'(1) << FRAC_BITS);
   localparam logic signed [MW-1:0] HalfM   = MW'(longint'(1) << (FRAC_BITS - 1));
   localparam logic signed [GW-1:0] HalfG   = GW'(longint'(1) << (FRAC_BITS - 1));
   localparam logic signed [GW-1:0] MaxV    = GW'((longint'(1) << (DATA_WIDTH - 1)) - 1);
   localparam logic signed [GW-1:0] MinV    = GW'(-(longint'(1) << (DATA_WIDTH - 1)));

   ctl_type ctl5_ff, ctl6_ff, ctl7_ff, ctl8_ff;
   logic signed [DATA_WIDTH-1:0] x5_ff, x6_ff, x7_ff;
   logic signed [DATA_WIDTH-1:0] g5_ff, g6_ff, g7_ff;
   logic signed [TW-1:0] f5_ff, f6_ff, f7_ff;

   logic signed [TW-1:0]         b;
   logic signed [MW-1:0]         m5_in, m5_ff, rm;
   logic signed [TW-1:0]         d6_in, d6_ff;
   logic signed [GW-1:0]         gd7_in, gd7_ff, rg, r;
   logic signed [DATA_WIDTH-1:0] value8_in, value8_ff;

   // Stage 5: f*(1-f) for sigmoid, f*f for tanh.
   always_comb begin
      b     = (up_ctl.kind == KIND_SIGMOID) ? One - up_f : up_f;
      m5_in = MW'(up_f) * MW'(b);
   end

   // Stage 6: derivative in the data format.
   always_comb begin
      rm    = (m5_ff + HalfM) >>> FRAC_BITS;
      d6_in = (ctl5_ff.kind == KIND_TANH) ? One - TW'(rm) : TW'(rm);
   end

   // Stage 7: gradient times derivative.
   always_comb begin
      gd7_in = GW'(g6_ff) * GW'(d6_ff);
   end

   // Stage 8: pick the result for the mode and kind, then saturate.
   always_comb begin
      rg = (gd7_ff + HalfG) >>> FRAC_BITS;
      unique case (ctl7_ff.kind)
         KIND_SIGMOID, KIND_TANH: begin
            r = ctl7_ff.backward ? rg : GW'(f7_ff);
         end
         KIND_RELU: begin
            if (ctl7_ff.backward) begin
               r = x7_ff[DATA_WIDTH-1] ? '0 : GW'(g7_ff);
            end else begin
               r = (x7_ff > 0) ? GW'(x7_ff) : '0;
            end
         end
         KIND_NONE: begin
            r = '0;
         end
         default: begin
            r = '0;
         end
      endcase
      if (r > MaxV) begin
         value8_in = DATA_WIDTH'(MaxV);
      end else if (r < MinV) begin
         value8_in = DATA_WIDTH'(MinV);
      end else begin
         value8_in = DATA_WIDTH'(r);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl5_ff <= '0;
         ctl6_ff <= '0;
         ctl7_ff <= '0;
         ctl8_ff <= '0;
      end else if (advance) begin
         ctl5_ff <= up_ctl;
         ctl6_ff <= ctl5_ff;
         ctl7_ff <= ctl6_ff;
         ctl8_ff <= ctl7_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         x5_ff     <= up_x;
         g5_ff     <= up_g;
         f5_ff     <= up_f;
         m5_ff     <= m5_in;
         x6_ff     <= x5_ff;
         g6_ff     <= g5_ff;
         f6_ff     <= f5_ff;
         d6_ff     <= d6_in;
         x7_ff     <= x6_ff;
         g7_ff     <= g6_ff;
         f7_ff     <= f6_ff;
         gd7_ff    <= gd7_in;
         value8_ff <= value8_in;
      end
   end

   assign dn_valid = ctl8_ff.valid;
   assign dn_value = value8_ff;

   a_none_is_zero: assert property (@(posedge clock) disable iff (reset)
      (ctl8_ff.valid && ctl8_ff.kind == KIND_NONE) |-> (value8_ff == '0))
      else $error("kind none produced a nonzero result");

   a_relu_forward_sign: assert property (@(posedge clock) disable iff (reset)
      (ctl8_ff.valid && ctl8_ff.kind == KIND_RELU && !ctl8_ff.backward)
      |-> !value8_ff[DATA_WIDTH-1])
      else $error("forward ReLU produced a negative result");

endmodule

[rtl/activation_forward_backward_unit.sv]
// Top level of the activation forward/backward unit: configuration port,
// table stages and derivative stages. Depends on afb_pkg, afb_csr,
// afb_interp and afb_grad.
//
//   channel   direction  handshake             payload
//   req       in         req_valid/req_ready   req_func, req_pre_activation,
//                                              req_gradient_in
//   rsp       out        rsp_valid/rsp_ready   rsp_value
//   csr       in         psel/penable/pready   paddr, pwrite, pwdata, prdata
//
// One request per cycle while the output is not stalled; a request passes through
// the eight register stages of the datapath, the first of which is loaded at the
// edge that accepts it, and its result is offered on rsp from the last stage.
// All stages advance together; when a result waits at the output and is not
// taken, the whole pipeline holds and req_ready is low.
// Reset clears the stage valid bits and sets the activation kind to sigmoid.
module activation_forward_backward_unit #(
   parameter int DATA_WIDTH    = afb_pkg::AFB_DATA_WIDTH,
   parameter int FRAC_BITS     = afb_pkg::AFB_FRAC_BITS,
   parameter int TABLE_ENTRIES = afb_pkg::AFB_TABLE_ENTRIES
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic                         req_func,
   input  logic signed [DATA_WIDTH-1:0] req_pre_activation,
   input  logic signed [DATA_WIDTH-1:0] req_gradient_in,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic signed [DATA_WIDTH-1:0] rsp_value,
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic [2:0]                   paddr,
   input  logic [31:0]                  pwdata,
   output logic [31:0]                  prdata,
   output logic                         pready
);
   import afb_pkg::*;

   kind_type kind;
   ctl_type  in_ctl;
   ctl_type  mid_ctl;
   logic     advance;
   logic signed [FRAC_BITS+1:0]  mid_f;
   logic signed [DATA_WIDTH-1:0] mid_x;
   logic signed [DATA_WIDTH-1:0] mid_g;

   // The pipeline moves whenever the output register is empty or being read.
   assign advance   = !rsp_valid || rsp_ready;
   assign req_ready = advance;

   always_comb begin
      in_ctl.valid    = req_valid;
      in_ctl.backward = req_func;
      in_ctl.kind     = kind;
   end

   afb_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .kind    (kind)
   );

   afb_interp #(
      .DATA_WIDTH    (DATA_WIDTH),
      .FRAC_BITS     (FRAC_BITS),
      .TABLE_ENTRIES (TABLE_ENTRIES)
   ) u_interp (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .up_ctl  (in_ctl),
      .up_x    (req_pre_activation),
      .up_g    (req_gradient_in),
      .dn_ctl  (mid_ctl),
      .dn_f    (mid_f),
      .dn_x    (mid_x),
      .dn_g    (mid_g)
   );

   afb_grad #(
      .DATA_WIDTH (DATA_WIDTH),
      .FRAC_BITS  (FRAC_BITS)
   ) u_grad (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .up_ctl   (mid_ctl),
      .up_f     (mid_f),
      .up_x     (mid_x),
      .up_g     (mid_g),
      .dn_valid (rsp_valid),
      .dn_value (rsp_value)
   );

endmodule

[test/activation_forward_backward_unit_test.sv]
`timescale 1ns / 1ps
// Testbench of activation_forward_backward_unit: streams requests under every activation
// kind and compares each result with a fixed-point predictor kept in this file.
// Depends on afb_pkg and the RTL of the unit.
module activation_forward_backward_unit_test;
   import afb_pkg::*;

   localparam int DW = AFB_DATA_WIDTH;
   localparam int FRAC = AFB_FRAC_BITS;
   localparam int POINTS = AFB_TABLE_ENTRIES;
   localparam int HALF_SPAN = 8 << FRAC;
   localparam int POINT_STEP = (16 << FRAC) / POINTS;
   localparam longint Q31_UNIT = longint'(1) << 31;
   localparam longint FIXED_ONE = longint'(1) << FRAC;
   localparam longint VALUE_MAX = (longint'(1) << (DW - 1)) - 1;
   localparam longint VALUE_MIN = -VALUE_MAX - 1;
   localparam logic [2:0] KIND_REG_ADDR = 3'(4 * CSR_IDX_KIND);
   localparam int STALL_LIMIT = 4000;
   localparam int DRAIN_CYCLES = 16;
   localparam int REPORT_LIMIT = 10;

   typedef logic signed [DW-1:0] q_value_type;

   typedef struct {
      kind_type    kind;
      logic        backward;
      q_value_type x;
      q_value_type g;
      q_value_type value;
   } activation_result_type;

   localparam q_value_type X_MIN = q_value_type'(VALUE_MIN);
   localparam q_value_type X_MAX = q_value_type'(VALUE_MAX);

   logic clock;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic req_func = 1'b0;
   q_value_type req_pre_activation = '0;
   q_value_type req_gradient_in = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   q_value_type rsp_value;
   logic psel = 1'b0;
   logic penable = 1'b0;
   logic pwrite = 1'b0;
   logic [2:0] paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic pready;

   longint sigmoid_points [POINTS+1];
   longint tanh_points [POINTS+1];
   kind_type active_kind = KIND_SIGMOID;
   activation_result_type pending_results[$];
   activation_result_type expected_result;
   int failure_count = 0;
   int send_gap_pct = 0;
   int recv_gap_pct = 0;
   int rsp_hold_cycles = 0;
   int idle_cycles = 0;

   activation_forward_backward_unit DUT (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_func           (req_func),
      .req_pre_activation (req_pre_activation),
      .req_gradient_in    (req_gradient_in),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_value          (rsp_value),
      .psel               (psel),
      .penable            (penable),
      .pwrite             (pwrite),
      .paddr              (paddr),
      .pwdata             (pwdata),
      .prdata             (prdata),
      .pready             (pready)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Rounds to nearest with ties toward plus infinity.
   function automatic longint round_shift(input longint v, input int s);
      return (v + (longint'(1) << (s - 1))) >>> s;
   endfunction

   function automatic longint q31_product(input longint a, input longint b);
      return (a * b + (Q31_UNIT >>> 1)) >>> 31;
   endfunction

   // exp(-|x|) comes from a fifth-order series on |x|/256 that is squared eight times.
   function automatic void build_curve_tables();
      longint offset;
      longint magnitude;
      longint arg;
      longint term;
      longint e;
      longint e_sq;
      longint den;
      longint tanh_mag;
      for (int k = 0; k <= POINTS; k++) begin
         offset = 2 * k - POINTS;
         magnitude = (offset < 0) ? -offset : offset;
         arg = ((magnitude << 26) + POINTS / 2) / POINTS;
         term = Q31_UNIT;
         e = Q31_UNIT;
         for (int n = 1; n <= 5; n++) begin
            term = q31_product(term, arg) / n;
            e = (n % 2 == 1) ? e - term : e + term;
         end
         repeat (8) e = q31_product(e, e);
         e_sq = q31_product(e, e);
         den = Q31_UNIT + e;
         sigmoid_points[k] = ((((offset < 0) ? e : Q31_UNIT) << FRAC) + den / 2) / den;
         den = Q31_UNIT + e_sq;
         tanh_mag = (((Q31_UNIT - e_sq) << FRAC) + den / 2) / den;
         tanh_points[k] = (offset < 0) ? -tanh_mag : tanh_mag;
      end
   endfunction

   function automatic longint curve_lookup(input bit use_tanh, input longint x);
      longint span;
      longint offset;
      longint scaled;
      longint idx;
      longint frac;
      longint lo;
      longint hi;
      span = longint'(16) << FRAC;
      offset = x + HALF_SPAN;
      if (offset < 0) begin
         idx = 0;
         frac = 0;
      end else if (offset >= span) begin
         idx = POINTS;
         frac = 0;
      end else begin
         scaled = offset * POINTS;
         idx = scaled / span;
         frac = scaled % span;
      end
      lo = use_tanh ? tanh_points[idx] : sigmoid_points[idx];
      if (frac == 0) return lo;
      hi = use_tanh ? tanh_points[idx+1] : sigmoid_points[idx+1];
      return lo + round_shift((hi - lo) * frac, FRAC + 4);
   endfunction

   function automatic q_value_type predict_activation(input kind_type kind,
                                                      input logic backward,
                                                      input q_value_type x_in,
                                                      input q_value_type g_in);
      longint x;
      longint g;
      longint f;
      longint slope;
      longint r;
      x = x_in;
      g = g_in;
      r = 0;
      case (kind)
         KIND_SIGMOID: begin
            f = curve_lookup(1'b0, x);
            if (backward) begin
               slope = round_shift(f * (FIXED_ONE - f), FRAC);
               r = round_shift(g * slope, FRAC);
            end else begin
               r = f;
            end
         end
         KIND_RELU: begin
            if (backward) r = (x >= 0) ? g : 0;
            else r = (x > 0) ? x : 0;
         end
         KIND_TANH: begin
            f = curve_lookup(1'b1, x);
            if (backward) begin
               slope = FIXED_ONE - round_shift(f * f, FRAC);
               r = round_shift(g * slope, FRAC);
            end else begin
               r = f;
            end
         end
         default: r = 0;
      endcase
      if (r > VALUE_MAX) r = VALUE_MAX;
      if (r < VALUE_MIN) r = VALUE_MIN;
      return q_value_type'(r);
   endfunction

   // Most values land inside the table range, some right on a table point.
   function automatic q_value_type random_pre_activation();
      case ($urandom_range(7))
         0, 1: return q_value_type'($urandom);
         2, 3, 4: return q_value_type'(int'($urandom_range(2 * HALF_SPAN - 1)) - HALF_SPAN);
         5: return q_value_type'((int'($urandom_range(POINTS)) - POINTS / 2) * POINT_STEP
                                 + int'($urandom_range(2)) - 1);
         6: return q_value_type'(int'($urandom_range(64)) - 32);
         default: begin
            case ($urandom_range(3))
               0: return X_MIN;
               1: return X_MAX;
               2: return q_value_type'(-HALF_SPAN - 1);
               default: return q_value_type'(HALF_SPAN);
            endcase
         end
      endcase
   endfunction

   function automatic q_value_type random_gradient();
      case ($urandom_range(7))
         0: return X_MAX;
         1: return X_MIN;
         default: return q_value_type'($urandom);
      endcase
   endfunction

   function automatic void note_failure(input string msg);
      failure_count++;
      if (failure_count <= REPORT_LIMIT) $display("ERROR: %s", msg);
   endfunction

   task automatic write_kind(input kind_type kind);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= KIND_REG_ADDR;
      pwdata <= {30'($urandom), kind};
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      active_kind = kind;
   endtask

   // Leaves req_valid high on return, so the next request follows without a gap.
   task automatic send_request(input logic backward, input q_value_type x,
                               input q_value_type g);
      activation_result_type accepted;
      if ($urandom_range(99) < send_gap_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_gap_pct);
      end
      req_valid <= 1'b1;
      req_func <= backward;
      req_pre_activation <= x;
      req_gradient_in <= g;
      do @(posedge clock); while (!req_ready);
      accepted.kind = active_kind;
      accepted.backward = backward;
      accepted.x = x;
      accepted.g = g;
      accepted.value = predict_activation(active_kind, backward, x, g);
      pending_results.push_back(accepted);
   endtask

   task automatic wait_until_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_results.size() != 0);
   endtask

   task automatic test_directed_cases();
      send_gap_pct = 0;
      recv_gap_pct = 0;
      // Sigmoid out of reset: far below the table, the first and last points, and the
      // steepest derivative with both extreme gradients.
      send_request(1'b0, X_MIN, q_value_type'(0));
      send_request(1'b0, q_value_type'(-HALF_SPAN), q_value_type'(0));
      send_request(1'b0, q_value_type'(HALF_SPAN), q_value_type'(0));
      send_request(1'b1, q_value_type'(0), X_MAX);
      send_request(1'b1, q_value_type'(-1), X_MIN);
      wait_until_drained();
      // ReLU: zero gives zero forward but passes the gradient backward.
      write_kind(KIND_RELU);
      send_request(1'b0, q_value_type'(0), X_MAX);
      send_request(1'b0, q_value_type'(1), q_value_type'(0));
      send_request(1'b0, X_MAX, q_value_type'(0));
      send_request(1'b0, q_value_type'(-1), X_MAX);
      send_request(1'b1, q_value_type'(0), X_MIN);
      send_request(1'b1, q_value_type'(-1), X_MAX);
      wait_until_drained();
      write_kind(KIND_TANH);
      send_request(1'b0, q_value_type'(-HALF_SPAN - 1), q_value_type'(0));
      send_request(1'b0, q_value_type'(HALF_SPAN - 1), q_value_type'(0));
      send_request(1'b0, X_MAX, q_value_type'(0));
      send_request(1'b1, q_value_type'(0), X_MAX);
      send_request(1'b1, q_value_type'(-HALF_SPAN), X_MIN);
      wait_until_drained();
      // No activation gives zero in both modes.
      write_kind(KIND_NONE);
      send_request(1'b0, q_value_type'(100), X_MAX);
      send_request(1'b1, q_value_type'(-5), q_value_type'(7));
      wait_until_drained();
   endtask

   task automatic test_random_stream(input int gap_send, input int gap_recv,
                                     input int per_kind);
      int first;
      kind_type kind;
      send_gap_pct = gap_send;
      recv_gap_pct = gap_recv;
      first = $urandom_range(3);
      for (int i = 0; i < 4; i++) begin
         kind = kind_type'(2'(first + i));
         write_kind(kind);
         repeat (per_kind) begin
            send_request(1'($urandom), random_pre_activation(), random_gradient());
         end
         wait_until_drained();
      end
   endtask

   task automatic test_output_stall_fills_pipeline();
      send_gap_pct = 0;
      recv_gap_pct = 0;
      write_kind(KIND_TANH);
      // The output is held off long enough for the pipeline to fill and stall the input.
      rsp_hold_cycles = 250;
      repeat (40) send_request(1'($urandom), random_pre_activation(), random_gradient());
      wait_until_drained();
   endtask

   task automatic test_pause_until_drained();
      send_gap_pct = 6;
      recv_gap_pct = 30;
      write_kind(KIND_SIGMOID);
      repeat (30) send_request(1'b1, random_pre_activation(), random_gradient());
      wait_until_drained();
      repeat (30) send_request(1'($urandom), random_pre_activation(), random_gradient());
      wait_until_drained();
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            note_failure($sformatf("result %0d arrived with nothing expected", rsp_value));
         end else begin
            expected_result = pending_results.pop_front();
            if (rsp_value !== expected_result.value) begin
               note_failure($sformatf("%s backward=%0b x=%0d g=%0d: expected %0d, got %0d",
                                      expected_result.kind.name(), expected_result.backward,
                                      expected_result.x, expected_result.g,
                                      expected_result.value, rsp_value));
            end
         end
      end
      if (rsp_hold_cycles > 0) begin
         rsp_ready <= 1'b0;
         rsp_hold_cycles--;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_gap_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   initial begin
      build_curve_tables();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      test_directed_cases();
      test_random_stream(6, 71, 150);
      test_random_stream(71, 6, 150);
      test_random_stream(0, 0, 150);
      test_output_stall_fills_pipeline();
      test_pause_until_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (failure_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

[filelist.f]
rtl/afb_pkg.sv
rtl/afb_csr.sv
rtl/afb_interp.sv
rtl/afb_grad.sv
rtl/activation_forward_backward_unit.sv
test/activation_forward_backward_unit_test.sv
